// ===== rtl/vur_pkg.sv =====
// Shared types, constants and a helper function for the video unit register port.
package vur_pkg;

  localparam int VIDEO_MEM_DEPTH  = 16384;
  localparam int SPRITE_MEM_DEPTH = 256;
  localparam int VADDR_W          = 14;
  localparam int OAM_AW           = $clog2(SPRITE_MEM_DEPTH);
  localparam int VRAM_AW          = $clog2(VIDEO_MEM_DEPTH);

  localparam logic [VADDR_W-1:0] NT_MIRROR_LO    = 14'h2FFF;
  localparam logic [VADDR_W-1:0] PAL_BASE        = 14'h3F00;
  localparam logic [VADDR_W-1:0] PAL_TOP         = 14'h3F1F;
  localparam logic [VADDR_W-1:0] NT_MIRROR_STEP  = 14'h1000;
  localparam logic [VADDR_W-1:0] PAL_MIRROR_STEP = 14'h0020;
  localparam logic [VADDR_W-1:0] PAL_THRESHOLD   = 14'h3EFF;
  localparam logic [VADDR_W-1:0] ROW_STEP        = 14'd32;
  localparam logic [VADDR_W-1:0] COL_STEP        = 14'd1;

  typedef enum logic [3:0] {
    OP_RD_CTRL    = 4'd0,
    OP_WR_CTRL    = 4'd1,
    OP_RD_MASK    = 4'd2,
    OP_WR_MASK    = 4'd3,
    OP_RD_STATUS  = 4'd4,
    OP_WR_OAMADDR = 4'd5,
    OP_RD_OAM     = 4'd6,
    OP_WR_OAM     = 4'd7,
    OP_WR_SCROLL  = 4'd8,
    OP_WR_ADDR    = 4'd9,
    OP_RD_DATA    = 4'd10,
    OP_WR_DATA    = 4'd11,
    OP_VBL_BEGIN  = 4'd12,
    OP_VBL_END    = 4'd13
  } op_t;

  // Where the result byte of a request comes from once memory data is back.
  typedef enum logic [1:0] {
    RSEL_REG,
    RSEL_SPRITE,
    RSEL_BUFFERED,
    RSEL_PALETTE
  } rsel_t;

  typedef struct packed {
    rsel_t      sel;
    logic [7:0] value;
  } stage_t;

  typedef struct packed {
    logic               vram_rd;
    logic               vram_wr;
    logic               oam_rd;
    logic               oam_wr;
    logic [VADDR_W-1:0] vram_addr;
    logic [OAM_AW-1:0]  oam_addr;
    logic [7:0]         wdata;
  } mem_req_t;

  // Nametable and palette mirrors, applied once.
  function automatic logic [VADDR_W-1:0] mirror_addr(input logic [VADDR_W-1:0] a);
    logic [VADDR_W-1:0] m;
    m = a;
    if (a > NT_MIRROR_LO && a < PAL_BASE) begin
      m = a - NT_MIRROR_STEP;
    end else if (a > PAL_TOP) begin
      m = a - PAL_MIRROR_STEP;
    end
    return m;
  endfunction

endpackage

// ===== rtl/vur_mem.sv =====
// Single-port synchronous byte memory with a registered read.
module vur_mem #(
  parameter int DEPTH = vur_pkg::SPRITE_MEM_DEPTH
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [7:0]               wdata,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/vur_regs.sv =====
// Register file and request decode: updates control state and issues memory accesses.
module vur_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [3:0]        op,
  input  logic [7:0]        data_in,
  output vur_pkg::stage_t   stage,
  output vur_pkg::mem_req_t mem_req
);
  import vur_pkg::*;

  logic [7:0]         control_reg, control_next;
  logic [7:0]         mask_reg, mask_next;
  logic [7:0]         status_reg, status_next;
  logic [VADDR_W-1:0] video_address, video_address_next;
  logic               address_phase, address_phase_next;
  logic [VADDR_W-1:0] sprite_address, sprite_address_next;
  logic               sprite_phase, sprite_phase_next;
  logic [15:0]        scroll_value, scroll_value_next;
  logic               scroll_phase, scroll_phase_next;
  logic               vblank_active, vblank_active_next;
  logic [VADDR_W-1:0] step;
  op_t                opc;

  always_comb begin
    opc  = op_t'(op);
    step = control_reg[2] ? ROW_STEP : COL_STEP;

    stage.sel   = RSEL_REG;
    stage.value = 8'h00;

    mem_req.vram_rd   = 1'b0;
    mem_req.vram_wr   = 1'b0;
    mem_req.oam_rd    = 1'b0;
    mem_req.oam_wr    = 1'b0;
    mem_req.vram_addr = mirror_addr(video_address);
    mem_req.oam_addr  = sprite_address[OAM_AW-1:0];
    mem_req.wdata     = data_in;

    control_next        = control_reg;
    mask_next           = mask_reg;
    status_next         = status_reg;
    video_address_next  = video_address;
    address_phase_next  = address_phase;
    sprite_address_next = sprite_address;
    sprite_phase_next   = sprite_phase;
    scroll_value_next   = scroll_value;
    scroll_phase_next   = scroll_phase;
    vblank_active_next  = vblank_active;

    // Every CPU write leaves its low five bits in the status register.
    if (opc inside {OP_WR_CTRL, OP_WR_MASK, OP_WR_OAMADDR, OP_WR_OAM,
                    OP_WR_SCROLL, OP_WR_ADDR, OP_WR_DATA}) begin
      status_next[4:0] = data_in[4:0];
    end

    case (opc)
      OP_RD_CTRL: begin
        stage.value = control_reg;
      end
      OP_WR_CTRL: begin
        control_next = data_in;
      end
      OP_RD_MASK: begin
        stage.value = mask_reg;
      end
      OP_WR_MASK: begin
        mask_next = data_in;
      end
      OP_RD_STATUS: begin
        stage.value = status_reg;
        if (!vblank_active) begin
          status_next[7] = 1'b0;
        end
        video_address_next = '0;
        address_phase_next = 1'b0;
        scroll_phase_next  = 1'b0;
        sprite_phase_next  = 1'b0;
      end
      OP_WR_OAMADDR: begin
        if (!sprite_phase) begin
          sprite_address_next = {data_in[5:0], 8'h00};
        end else begin
          sprite_address_next = sprite_address | {6'b0, data_in};
        end
        sprite_phase_next = !sprite_phase;
      end
      OP_RD_OAM: begin
        stage.sel      = RSEL_SPRITE;
        mem_req.oam_rd = accept;
        if (!vblank_active) begin
          sprite_address_next = sprite_address + COL_STEP;
        end
      end
      OP_WR_OAM: begin
        mem_req.oam_wr      = accept;
        sprite_address_next = sprite_address + COL_STEP;
      end
      OP_WR_SCROLL: begin
        if (!scroll_phase) begin
          scroll_value_next = {data_in, 8'h00};
        end else begin
          scroll_value_next = scroll_value | {8'h00, data_in};
        end
        scroll_phase_next = !scroll_phase;
      end
      OP_WR_ADDR: begin
        if (!address_phase) begin
          video_address_next = {data_in[5:0], 8'h00};
        end else begin
          video_address_next = video_address | {6'b0, data_in};
        end
        address_phase_next = !address_phase;
      end
      OP_RD_DATA: begin
        stage.sel          = (video_address > PAL_THRESHOLD) ? RSEL_PALETTE : RSEL_BUFFERED;
        mem_req.vram_rd    = accept;
        video_address_next = video_address + step;
      end
      OP_WR_DATA: begin
        mem_req.vram_wr    = accept;
        video_address_next = video_address + step;
      end
      OP_VBL_BEGIN: begin
        vblank_active_next = 1'b1;
        status_next[7]     = 1'b1;
      end
      OP_VBL_END: begin
        vblank_active_next = 1'b0;
        status_next[7]     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg    <= '0;
      mask_reg       <= '0;
      status_reg     <= '0;
      video_address  <= '0;
      address_phase  <= 1'b0;
      sprite_address <= '0;
      sprite_phase   <= 1'b0;
      scroll_value   <= '0;
      scroll_phase   <= 1'b0;
      vblank_active  <= 1'b0;
    end else if (accept) begin
      control_reg    <= control_next;
      mask_reg       <= mask_next;
      status_reg     <= status_next;
      video_address  <= video_address_next;
      address_phase  <= address_phase_next;
      sprite_address <= sprite_address_next;
      sprite_phase   <= sprite_phase_next;
      scroll_value   <= scroll_value_next;
      scroll_phase   <= scroll_phase_next;
      vblank_active  <= vblank_active_next;
    end
  end

endmodule

// ===== rtl/vur_resp.sv =====
// Result path: waits for memory data, applies the read buffer and holds the output register.
module vur_resp (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  vur_pkg::stage_t stage,
  input  logic [7:0]      vram_rdata,
  input  logic [7:0]      oam_rdata,
  input  logic            rsp_stall,
  output logic            req_stall,
  output logic            rsp_valid,
  output logic [7:0]      read_data
);
  import vur_pkg::*;

  logic       s1_valid;
  stage_t     s1;
  logic [7:0] read_buffer;
  logic       s1_move;
  logic [7:0] result;

  // The memory data registers only load on an accepted request, so they hold
  // while the request waits here.
  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_move;

  always_comb begin
    case (s1.sel)
      RSEL_REG:      result = s1.value;
      RSEL_SPRITE:   result = oam_rdata;
      RSEL_BUFFERED: result = read_buffer;
      RSEL_PALETTE:  result = vram_rdata;
      default:       result = s1.value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      rsp_valid   <= 1'b0;
      read_buffer <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        rsp_valid <= 1'b1;
        if (s1.sel == RSEL_BUFFERED || s1.sel == RSEL_PALETTE) begin
          read_buffer <= vram_rdata;
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage;
    end
    if (s1_move) begin
      read_data <= result;
    end
  end

endmodule

// ===== rtl/video_unit_register_port.sv =====
// Top level of the video unit register port: CPU register requests and vblank events.
// Path: an accepted request is registered in the stage register, the memories
// register its read data, and it then moves to the output register to be taken.
// Throughput: one request per cycle unless a stalled result holds the stage; the
// output register frees the next slot as the result is taken.
// Reset clears the port registers, address latches and the read buffer; the video
// and sprite memories are not cleared and hold nothing valid until written.
module video_unit_register_port #(
  parameter int VIDEO_MEM_DEPTH  = vur_pkg::VIDEO_MEM_DEPTH,
  parameter int SPRITE_MEM_DEPTH = vur_pkg::SPRITE_MEM_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic [3:0] op,
  input  logic [7:0] data_in,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_data
);
  import vur_pkg::*;

  localparam int VAW = $clog2(VIDEO_MEM_DEPTH);
  localparam int SAW = $clog2(SPRITE_MEM_DEPTH);

  logic       accept;
  stage_t     stage;
  mem_req_t   mem_req;
  logic [7:0] vram_rdata;
  logic [7:0] oam_rdata;

  assign accept = req_valid && !req_stall;

  vur_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .op      (op),
    .data_in (data_in),
    .stage   (stage),
    .mem_req (mem_req)
  );

  vur_mem #(
    .DEPTH (VIDEO_MEM_DEPTH)
  ) u_vram (
    .clk   (clk),
    .rd_en (mem_req.vram_rd),
    .wr_en (mem_req.vram_wr),
    .addr  (mem_req.vram_addr[VAW-1:0]),
    .wdata (mem_req.wdata),
    .rdata (vram_rdata)
  );

  vur_mem #(
    .DEPTH (SPRITE_MEM_DEPTH)
  ) u_oam (
    .clk   (clk),
    .rd_en (mem_req.oam_rd),
    .wr_en (mem_req.oam_wr),
    .addr  (mem_req.oam_addr[SAW-1:0]),
    .wdata (mem_req.wdata),
    .rdata (oam_rdata)
  );

  vur_resp u_resp (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .stage      (stage),
    .vram_rdata (vram_rdata),
    .oam_rdata  (oam_rdata),
    .rsp_stall  (rsp_stall),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .read_data  (read_data)
  );

endmodule

// ===== rtl/vur_checker.sv =====
// Port-level checks of the video unit register port, bound to the top level.
module vur_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic [7:0] read_data
);

  logic [1:0] pending;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid && !req_stall;
  assign rsp_acc = rsp_valid && !rsp_stall;

  // Requests accepted whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, req_acc} - {1'b0, rsp_acc};
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result shown with no request outstanding");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two requests in flight");

  a_free_slot: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> !req_stall)
    else $error("request stalled while the output register is empty");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data))
    else $error("stalled result changed");

endmodule

bind video_unit_register_port vur_checker u_vur_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the video unit register port.
`timescale 1ns / 1ps

module tb_top;
  import vur_pkg::*;

  localparam logic [3:0] OP_SPARE_A = 4'd14;
  localparam logic [3:0] OP_SPARE_B = 4'd15;

  // Tracks the register port state, works out the byte each request returns
  // and compares the returned bytes in order.
  class port_scoreboard;
    logic [7:0]  ctrl_q, mask_q, status_q, buffer_q;
    logic [13:0] vaddr_q, saddr_q;
    logic [15:0] scroll_q;
    bit          vaddr_lo_next, saddr_lo_next, scroll_lo_next, vblank_q;
    logic [7:0]  vram [VIDEO_MEM_DEPTH];
    bit          vram_set [VIDEO_MEM_DEPTH];
    logic [7:0]  oam [SPRITE_MEM_DEPTH];
    bit          oam_set [SPRITE_MEM_DEPTH];
    logic [7:0]  read_bytes_due [$];
    int          errors;

    function new();
      ctrl_q = '0;
      mask_q = '0;
      status_q = '0;
      buffer_q = '0;
      vaddr_q = '0;
      saddr_q = '0;
      scroll_q = '0;
      vaddr_lo_next = 1'b0;
      saddr_lo_next = 1'b0;
      scroll_lo_next = 1'b0;
      vblank_q = 1'b0;
      errors = 0;
    endfunction

    // Nametable and palette aliases fold down once.
    function logic [13:0] fold_video_addr(logic [13:0] a);
      if (a > 14'h2FFF && a < 14'h3F00) return a - 14'h1000;
      if (a > 14'h3F1F) return a - 14'h0020;
      return a;
    endfunction

    function bit reads_unwritten(logic [3:0] code);
      if (code == OP_RD_OAM) return !oam_set[saddr_q[7:0]];
      if (code == OP_RD_DATA) return !vram_set[fold_video_addr(vaddr_q)];
      return 1'b0;
    endfunction

    function void echo_low_bits(logic [7:0] d);
      status_q = {status_q[7:5], d[4:0]};
    endfunction

    function void step_vaddr();
      vaddr_q = vaddr_q + (ctrl_q[2] ? 14'd32 : 14'd1);
    endfunction

    function void note_request(logic [3:0] code, logic [7:0] d);
      logic [7:0]  r;
      logic [13:0] m;
      r = '0;
      m = fold_video_addr(vaddr_q);
      case (code)
        OP_RD_CTRL: r = ctrl_q;
        OP_WR_CTRL: begin
          ctrl_q = d;
          echo_low_bits(d);
        end
        OP_RD_MASK: r = mask_q;
        OP_WR_MASK: begin
          mask_q = d;
          echo_low_bits(d);
        end
        OP_RD_STATUS: begin
          r = status_q;
          if (!vblank_q) status_q[7] = 1'b0;
          vaddr_q = '0;
          vaddr_lo_next = 1'b0;
          saddr_lo_next = 1'b0;
          scroll_lo_next = 1'b0;
        end
        OP_WR_OAMADDR: begin
          if (!saddr_lo_next) saddr_q = {d[5:0], 8'h00};
          else saddr_q = saddr_q | {6'd0, d};
          saddr_lo_next = !saddr_lo_next;
          echo_low_bits(d);
        end
        OP_RD_OAM: begin
          r = oam[saddr_q[7:0]];
          if (!vblank_q) saddr_q = saddr_q + 14'd1;
        end
        OP_WR_OAM: begin
          oam[saddr_q[7:0]] = d;
          oam_set[saddr_q[7:0]] = 1'b1;
          saddr_q = saddr_q + 14'd1;
          echo_low_bits(d);
        end
        OP_WR_SCROLL: begin
          if (!scroll_lo_next) scroll_q = {d, 8'h00};
          else scroll_q = scroll_q | {8'd0, d};
          scroll_lo_next = !scroll_lo_next;
          echo_low_bits(d);
        end
        OP_WR_ADDR: begin
          if (!vaddr_lo_next) vaddr_q = {d[5:0], 8'h00};
          else vaddr_q = vaddr_q | {6'd0, d};
          vaddr_lo_next = !vaddr_lo_next;
          echo_low_bits(d);
        end
        OP_RD_DATA: begin
          // Palette reads bypass the buffer but still refill it.
          r = (vaddr_q > 14'h3EFF) ? vram[m] : buffer_q;
          buffer_q = vram[m];
          step_vaddr();
        end
        OP_WR_DATA: begin
          vram[m] = d;
          vram_set[m] = 1'b1;
          step_vaddr();
          echo_low_bits(d);
        end
        OP_VBL_BEGIN: begin
          vblank_q = 1'b1;
          status_q[7] = 1'b1;
        end
        OP_VBL_END: begin
          vblank_q = 1'b0;
          status_q[7] = 1'b0;
        end
        default: ;
      endcase
      read_bytes_due.push_back(r);
    endfunction

    function void check_read(logic [7:0] got);
      logic [7:0] want;
      if (read_bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual read_data=%02h", $time, got);
        return;
      end
      want = read_bytes_due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: read_data mismatch, expected %02h, actual %02h", $time, want, got);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [3:0] op = '0;
  logic [7:0] data_in = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [7:0] read_data;

  port_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  bit hold_req = 1'b0;

  video_unit_register_port i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .data_in   (data_in),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .read_data (read_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: check what is taken at this edge, then choose the next stall.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_read(read_data);
    rsp_stall <= hold_req || ($urandom_range(99) < stall_pct);
  end

  // A read of a never-written memory entry is turned into a write to it.
  task automatic issue(input logic [3:0] code, input logic [7:0] d);
    if (sb.reads_unwritten(code)) code = (code == OP_RD_OAM) ? OP_WR_OAM : OP_WR_DATA;
    req_valid <= 1'b1;
    op <= code;
    data_in <= d;
    do @(posedge clk); while (req_stall);
    sb.note_request(code, d);
    sent++;
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.read_bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    @(posedge clk);
    hold_req <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_req <= 1'b0;
  endtask

  // Writes a run of bytes through the data port, then points back and reads
  // them, one more than written so the buffered byte falls out.
  task automatic video_burst();
    logic [13:0] a;
    int n;
    case ($urandom_range(3))
      0: a = 14'($urandom_range(16'h1FFF));
      1: a = 14'h2000 + 14'($urandom_range(16'h0FFF));
      2: a = 14'h3000 + 14'($urandom_range(16'h0EFF));
      default: a = 14'h3F00 + 14'($urandom_range(16'h00FF));
    endcase
    n = $urandom_range(1, 8);
    if ($urandom_range(3) == 0) issue(OP_WR_CTRL, 8'($urandom));
    for (int round = 0; round < 2; round++) begin
      issue(OP_RD_STATUS, 8'($urandom));
      issue(OP_WR_ADDR, {2'($urandom), a[13:8]});
      issue(OP_WR_ADDR, a[7:0]);
      for (int i = 0; i < n + round; i++) begin
        issue(round ? OP_RD_DATA : OP_WR_DATA, 8'($urandom));
      end
    end
  endtask

  task automatic sprite_burst();
    logic [7:0] hi, lo;
    int n;
    bit hold_addr;
    hi = 8'($urandom);
    lo = 8'($urandom);
    n = $urandom_range(1, 8);
    hold_addr = ($urandom_range(3) == 0);
    for (int round = 0; round < 2; round++) begin
      issue(OP_RD_STATUS, 8'($urandom));
      issue(OP_WR_OAMADDR, hi);
      issue(OP_WR_OAMADDR, lo);
      if (round == 1 && hold_addr) issue(OP_VBL_BEGIN, 8'($urandom));
      for (int i = 0; i < n; i++) begin
        issue(round ? OP_RD_OAM : OP_WR_OAM, 8'($urandom));
      end
    end
    if (hold_addr) issue(OP_VBL_END, 8'($urandom));
  endtask

  task automatic register_mix();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(9))
        0: issue(OP_RD_CTRL, 8'($urandom));
        1: issue(OP_WR_CTRL, 8'($urandom));
        2: issue(OP_RD_MASK, 8'($urandom));
        3: issue(OP_WR_MASK, 8'($urandom));
        4, 5: issue(OP_RD_STATUS, 8'($urandom));
        6: issue(OP_WR_SCROLL, 8'($urandom));
        7: issue(OP_VBL_BEGIN, 8'($urandom));
        8: issue(OP_VBL_END, 8'($urandom));
        default: issue($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B, 8'($urandom));
      endcase
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    int target;
    int kind;
    idle_pct = idle;
    stall_pct = stall;
    target = sent + count;
    while (sent < target) begin
      kind = $urandom_range(99);
      if (kind < 40) video_burst();
      else if (kind < 60) sprite_burst();
      else if (kind < 80) register_mix();
      else repeat ($urandom_range(1, 8)) issue(4'($urandom_range(15)), 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(OP_WR_CTRL, 8'hFF);
    issue(OP_RD_CTRL, 8'h00);
    issue(OP_WR_MASK, 8'hFF);
    issue(OP_RD_MASK, 8'h00);
    issue(OP_VBL_BEGIN, 8'h00);
    issue(OP_RD_STATUS, 8'hFF);
    issue(OP_VBL_END, 8'h00);
    issue(OP_WR_SCROLL, 8'hFF);
    issue(OP_WR_SCROLL, 8'h00);
    // Sprite address at its top, so the write wraps it to zero.
    issue(OP_WR_OAMADDR, 8'hFF);
    issue(OP_WR_OAMADDR, 8'hFF);
    issue(OP_WR_OAM, 8'hA5);
    issue(OP_WR_OAMADDR, 8'h00);
    issue(OP_WR_OAMADDR, 8'hFF);
    // During vblank a sprite read leaves the address where it is.
    issue(OP_VBL_BEGIN, 8'h00);
    issue(OP_RD_OAM, 8'h00);
    issue(OP_VBL_END, 8'h00);
    issue(OP_RD_OAM, 8'h00);
    // Top video address: palette alias, then the address wraps.
    issue(OP_WR_ADDR, 8'hFF);
    issue(OP_WR_ADDR, 8'hFF);
    issue(OP_WR_DATA, 8'h5A);
    issue(OP_WR_ADDR, 8'h3F);
    issue(OP_WR_ADDR, 8'hFF);
    issue(OP_RD_DATA, 8'h00);
    issue(OP_SPARE_A, 8'hFF);
    issue(OP_SPARE_B, 8'h00);
    drain();

    run_phase(0, 0, 380);
    run_phase(71, 0, 380);
    run_phase(0, 71, 380);
    run_phase(37, 37, 380);

    // The result side holds off while requests keep coming, so the block
    // fills up and stalls its input.
    idle_pct = 0;
    stall_pct = 0;
    fork
      hold_off(250);
    join_none
    repeat (20) register_mix();
    drain();
    run_phase(20, 20, 60);
    drain();

    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vur_pkg.sv
rtl/vur_mem.sv
rtl/vur_regs.sv
rtl/vur_resp.sv
rtl/video_unit_register_port.sv
rtl/vur_checker.sv
tb/sv/tb_top.sv
